// ----- sv/lfuc_pkg.sv -----
`timescale 1ns / 1ps
package lfuc_pkg;

  // Default sizes and configuration reset.
  localparam int unsigned EntriesDef   = 16;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned CapWidth     = 5;
  localparam logic [CapWidth-1:0] CapReset = 5'd16;

  // Operation codes.
  typedef enum logic {
    OpGet = 1'b0,
    OpPut = 1'b1
  } op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDecide,
    StAge,
    StDone
  } state_e;

  // Request payload.
  typedef struct packed {
    op_e                opcode;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_data;
  } rsp_t;

endpackage

// ----- sv/lfuc_ram.sv -----
`timescale 1ns / 1ps
module lfuc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/lfu_cache_table_core.sv -----
`timescale 1ns / 1ps
// Channel   | Ports                                   | Direction
// request   | start_i, busy_o, req_i                  | in
// result    | done_o, rsp_o                           | out
// config    | cfg_we_i, cfg_wdata_i                   | in
//
// A request is taken when start_i is high and busy_o is low.
// Every request walks all ENTRIES slots of the entry memory once to find a
// match, a victim and a free slot, takes one decision step, and, if an
// entry changes, walks the memory again to age the recency ranks and write
// the entry. A result step then raises the strobe; busy_o drops in the
// cycle after the strobe. Both walks read the slots one by one through the
// single read port of the memory.
// Reset clears the valid marks and the fill level and sets the capacity to 16.
// The result strobe done_o lasts one cycle; the receiver cannot stall.
module lfu_cache_table_core import lfuc_pkg::*; #(
  parameter int unsigned ENTRIES    = EntriesDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  req_t                req_i,
  output logic                done_o,
  output rsp_t                rsp_o,
  input  logic                cfg_we_i,
  input  logic [CapWidth-1:0] cfg_wdata_i
);

  localparam int unsigned IW      = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW      = $clog2(ENTRIES + 1);
  localparam int unsigned RW      = IW;
  localparam int unsigned RankLsb = 0;
  localparam int unsigned CntLsb  = RW;
  localparam int unsigned DataLsb = RW + COUNT_BITS;
  localparam int unsigned KeyLsb  = DataLsb + 32;
  localparam int unsigned WW      = KeyLsb + 32;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // Control registers.
  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                pv_q, pv_d;
  logic [CapWidth-1:0] cap_q, cap_d;
  logic [CW-1:0]       fill_q, fill_d;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic                match_f_q, match_f_d;
  logic                vic_f_q, vic_f_d;
  logic                free_f_q, free_f_d;
  logic                all_q, all_d;

  // Payload registers.
  logic [IW-1:0]         pidx_q, pidx_d;
  req_t                  req_q, req_d;
  logic [IW-1:0]         match_idx_q, match_idx_d;
  logic [COUNT_BITS-1:0] match_cnt_q, match_cnt_d;
  logic [RW-1:0]         match_rank_q, match_rank_d;
  logic [31:0]           match_data_q, match_data_d;
  logic [IW-1:0]         vic_idx_q, vic_idx_d;
  logic [COUNT_BITS-1:0] vic_cnt_q, vic_cnt_d;
  logic [RW-1:0]         vic_rank_q, vic_rank_d;
  logic [IW-1:0]         free_idx_q, free_idx_d;
  logic [IW-1:0]         tgt_q, tgt_d;
  logic [RW-1:0]         lim_q, lim_d;
  logic [WW-1:0]         new_word_q, new_word_d;
  rsp_t                  rsp_q, rsp_d;

  // Memory port.
  logic          ram_we;
  logic [WW-1:0] ram_wdata;
  logic [WW-1:0] ram_rdata;

  lfuc_ram #(
    .WIDTH(WW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pidx_q),
    .wdata_i(ram_wdata),
    .raddr_i(cnt_q[IW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Fields of the word just read.
  logic [31:0]           r_key;
  logic [31:0]           r_data;
  logic [COUNT_BITS-1:0] r_cnt;
  logic [RW-1:0]         r_rank;
  logic                  r_valid;
  logic                  issue;

  assign r_key   = ram_rdata[KeyLsb +: 32];
  assign r_data  = ram_rdata[DataLsb +: 32];
  assign r_cnt   = ram_rdata[CntLsb +: COUNT_BITS];
  assign r_rank  = ram_rdata[RankLsb +: RW];
  assign r_valid = valid_q[pidx_q];
  assign issue   = cnt_q < CW'(ENTRIES);

  // Sequencer and shared compare unit.
  always_comb begin
    logic [CW-1:0]         cap_eff;
    logic [CW-1:0]         fill_n;
    logic [COUNT_BITS-1:0] touch_cnt;
    logic                  use_free;
    logic [WW-1:0]         age_word;

    state_d      = state_q;
    cnt_d        = cnt_q;
    pv_d         = pv_q;
    cap_d        = cap_q;
    fill_d       = fill_q;
    valid_d      = valid_q;
    match_f_d    = match_f_q;
    vic_f_d      = vic_f_q;
    free_f_d     = free_f_q;
    all_d        = all_q;
    pidx_d       = pidx_q;
    req_d        = req_q;
    match_idx_d  = match_idx_q;
    match_cnt_d  = match_cnt_q;
    match_rank_d = match_rank_q;
    match_data_d = match_data_q;
    vic_idx_d    = vic_idx_q;
    vic_cnt_d    = vic_cnt_q;
    vic_rank_d   = vic_rank_q;
    free_idx_d   = free_idx_q;
    tgt_d        = tgt_q;
    lim_d        = lim_q;
    new_word_d   = new_word_q;
    rsp_d        = rsp_q;
    ram_we       = 1'b0;
    ram_wdata    = new_word_q;
    done_o       = 1'b0;

    cap_eff   = (32'(cap_q) > ENTRIES) ? CW'(ENTRIES) : CW'(cap_q);
    fill_n    = fill_q;
    use_free  = 1'b1;
    touch_cnt = (match_cnt_q == CountMax) ? match_cnt_q : match_cnt_q + COUNT_BITS'(1);
    age_word  = ram_rdata;
    if (r_valid && (all_q || r_rank < lim_q)) begin
      age_word[RankLsb +: RW] = r_rank + RW'(1);
    end

    case (state_q)
      StIdle: begin
        if (start_i) begin
          req_d     = req_i;
          cnt_d     = '0;
          pv_d      = 1'b0;
          match_f_d = 1'b0;
          vic_f_d   = 1'b0;
          free_f_d  = 1'b0;
          state_d   = StScan;
        end
      end
      StScan: begin
        pv_d   = issue;
        pidx_d = cnt_q[IW-1:0];
        if (issue) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (pv_q) begin
          if (r_valid && !match_f_q && r_key == req_q.key) begin
            match_f_d    = 1'b1;
            match_idx_d  = pidx_q;
            match_cnt_d  = r_cnt;
            match_rank_d = r_rank;
            match_data_d = r_data;
          end
          if (r_valid && (!vic_f_q || r_cnt < vic_cnt_q ||
                          (r_cnt == vic_cnt_q && r_rank > vic_rank_q))) begin
            vic_f_d    = 1'b1;
            vic_idx_d  = pidx_q;
            vic_cnt_d  = r_cnt;
            vic_rank_d = r_rank;
          end
          if (!r_valid && !free_f_q) begin
            free_f_d   = 1'b1;
            free_idx_d = pidx_q;
          end
        end
        if (!issue && !pv_q) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        all_d           = 1'b0;
        rsp_d.hit       = match_f_q;
        rsp_d.read_data = '0;
        cnt_d           = '0;
        pv_d            = 1'b0;
        state_d         = StDone;
        if (req_q.opcode == OpGet) begin
          if (match_f_q) begin
            state_d         = StAge;
            tgt_d           = match_idx_q;
            lim_d           = match_rank_q;
            new_word_d      = {req_q.key, match_data_q, touch_cnt, RW'(0)};
            rsp_d.read_data = match_data_q;
          end else begin
            rsp_d.read_data = '1;
          end
        end else if (cap_eff != '0) begin
          if (match_f_q) begin
            state_d    = StAge;
            tgt_d      = match_idx_q;
            lim_d      = match_rank_q;
            new_word_d = {req_q.key, req_q.value, touch_cnt, RW'(0)};
          end else begin
            new_word_d = {req_q.key, req_q.value, COUNT_BITS'(1), RW'(0)};
            if (fill_q >= cap_eff) begin
              if (vic_f_q) begin
                use_free = 1'b0;
                state_d  = StAge;
                tgt_d    = vic_idx_q;
                lim_d    = vic_rank_q;
              end else begin
                // Fill level out of step with the valid marks: start over.
                fill_n = '0;
              end
            end
            if (use_free) begin
              fill_d = fill_n;
              if (free_f_q) begin
                state_d = StAge;
                tgt_d   = free_idx_q;
                all_d   = 1'b1;
                fill_d  = fill_n + CW'(1);
              end
            end
            if (state_d == StAge) begin
              valid_d[tgt_d] = 1'b1;
            end
          end
        end
      end
      StAge: begin
        pv_d   = issue;
        pidx_d = cnt_q[IW-1:0];
        if (issue) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (pv_q) begin
          ram_we    = 1'b1;
          ram_wdata = (pidx_q == tgt_q) ? new_word_q : age_word;
        end
        if (!issue && !pv_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        done_o  = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (cfg_we_i) begin
      cap_d = cfg_wdata_i;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      pv_q      <= 1'b0;
      cap_q     <= CapReset;
      fill_q    <= '0;
      valid_q   <= '0;
      match_f_q <= 1'b0;
      vic_f_q   <= 1'b0;
      free_f_q  <= 1'b0;
      all_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pv_q      <= pv_d;
      cap_q     <= cap_d;
      fill_q    <= fill_d;
      valid_q   <= valid_d;
      match_f_q <= match_f_d;
      vic_f_q   <= vic_f_d;
      free_f_q  <= free_f_d;
      all_q     <= all_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pidx_q       <= pidx_d;
    req_q        <= req_d;
    match_idx_q  <= match_idx_d;
    match_cnt_q  <= match_cnt_d;
    match_rank_q <= match_rank_d;
    match_data_q <= match_data_d;
    vic_idx_q    <= vic_idx_d;
    vic_cnt_q    <= vic_cnt_d;
    vic_rank_q   <= vic_rank_d;
    free_idx_q   <= free_idx_d;
    tgt_q        <= tgt_d;
    lim_q        <= lim_d;
    new_word_q   <= new_word_d;
    rsp_q        <= rsp_d;
  end

  assign busy_o = (state_q != StIdle);
  assign rsp_o  = rsp_q;

  // The result strobe only ends a request in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy_o)
    else $error("result strobe outside a request");

  // A taken request makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request taken but block not busy");

  // The fill level tracks the number of valid entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) == $countones(valid_q))
    else $error("fill level out of step with valid marks");

  // A memory write only happens during the ageing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == StAge))
    else $error("memory write outside the ageing pass");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import lfuc_pkg::*;

  // A narrow use count so that saturation is reached within a few requests.
  localparam int unsigned Slots    = 16;
  localparam int unsigned CountW   = 4;
  localparam int unsigned Settle   = 2 * Slots + 8;
  localparam int unsigned StallMax = 4000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  req_t                req = '0;
  logic                done;
  rsp_t                rsp;
  logic                cfg_we = 1'b0;
  logic [CapWidth-1:0] cfg_wdata = '0;

  lfu_cache_table_core #(
    .ENTRIES   (Slots),
    .COUNT_BITS(CountW)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_o     (busy),
    .req_i      (req),
    .done_o     (done),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the table, used to work out each expected result.
  logic                 shd_valid[Slots];
  logic [31:0]          shd_key[Slots];
  logic [31:0]          shd_data[Slots];
  logic [CountW-1:0]    shd_count[Slots];
  int unsigned          shd_rank[Slots];
  int unsigned          shd_fill = 0;
  logic [CapWidth-1:0]  shd_cap = CapReset;

  rsp_t        expected_rsp_q[$];
  logic [31:0] key_pool[24];
  int unsigned n_sent = 0, n_checked = 0, n_mismatch = 0, n_hits = 0, n_evict = 0;
  int unsigned n_cfg = 0, stall_cycles = 0;
  bit          no_gaps = 1'b0;

  // Every valid entry younger than the limit, or every valid entry when all is set, ages by one step.
  function automatic void age_ranks(int unsigned limit, bit all);
    for (int i = 0; i < Slots; i++) begin
      if (shd_valid[i] && (all || shd_rank[i] < limit)) begin
        shd_rank[i]++;
      end
    end
  endfunction

  function automatic void touch_entry(int unsigned s);
    if (shd_count[s] != {CountW{1'b1}}) begin
      shd_count[s]++;
    end
    age_ranks(shd_rank[s], 1'b0);
    shd_rank[s] = 0;
  endfunction

  function automatic rsp_t lfu_predict(req_t r);
    rsp_t        res;
    int unsigned cap_eff;
    int unsigned s;
    int unsigned dst;
    cap_eff = (shd_cap > Slots) ? Slots : shd_cap;
    s = Slots;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (shd_valid[i] && shd_key[i] == r.key) begin
        s = i;
      end
    end
    res.hit = (s < Slots);
    res.read_data = '0;
    if (r.opcode == OpGet) begin
      if (res.hit) begin
        touch_entry(s);
        res.read_data = shd_data[s];
      end else begin
        res.read_data = '1;
      end
    end else if (cap_eff != 0) begin
      if (res.hit) begin
        shd_data[s] = r.value;
        touch_entry(s);
      end else begin
        dst = Slots;
        // Full: lowest count goes, the oldest among equal counts.
        if (shd_fill >= cap_eff) begin
          for (int i = 0; i < Slots; i++) begin
            if (shd_valid[i] && (dst == Slots || shd_count[i] < shd_count[dst] ||
                (shd_count[i] == shd_count[dst] && shd_rank[i] > shd_rank[dst]))) begin
              dst = i;
            end
          end
          if (dst < Slots) begin
            age_ranks(shd_rank[dst], 1'b0);
            n_evict++;
          end else begin
            shd_fill = 0;
          end
        end
        if (dst >= Slots) begin
          for (int i = Slots - 1; i >= 0; i--) begin
            if (!shd_valid[i]) begin
              dst = i;
            end
          end
          if (dst < Slots) begin
            age_ranks(0, 1'b1);
            shd_fill++;
          end
        end
        if (dst < Slots) begin
          shd_valid[dst] = 1'b1;
          shd_key[dst]   = r.key;
          shd_data[dst]  = r.value;
          shd_count[dst] = CountW'(1);
          shd_rank[dst]  = 0;
        end
      end
    end
    return res;
  endfunction

  // Sends one request, at times after a random gap, unless gaps are off.
  task automatic send_req(op_e op, logic [31:0] k, logic [31:0] v);
    req_t r;
    r.opcode = op;
    r.key    = k;
    r.value  = v;
    if (!no_gaps && $urandom_range(99) < 23) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    expected_rsp_q.push_back(lfu_predict(r));
    n_sent++;
  endtask

  // Holds requests off until every result is back and the block is quiet.
  task automatic drain_results();
    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CapWidth-1:0] c);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shd_cap = c;
    n_cfg++;
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 75) begin
      return key_pool[$urandom_range(23)];
    end
    return $urandom;
  endfunction

  // Misses on an empty table, extreme keys and values, updates and hits.
  task automatic test_basic();
    send_req(OpGet, 32'h0, 32'h0);
    send_req(OpPut, 32'h8000_0000, 32'h7fff_ffff);
    send_req(OpPut, 32'h7fff_ffff, 32'h8000_0000);
    send_req(OpPut, 32'hffff_ffff, 32'hffff_ffff);
    send_req(OpPut, 32'h0, 32'h0);
    send_req(OpGet, 32'h8000_0000, 32'h1234_5678);
    send_req(OpGet, 32'h7fff_ffff, 32'h0);
    send_req(OpGet, 32'hffff_ffff, 32'h0);
    send_req(OpPut, 32'h0, 32'h5555_aaaa);
    send_req(OpGet, 32'h0, 32'h0);
    send_req(OpGet, 32'h0000_0001, 32'h0);
  endtask

  // Fill the table, then insert new keys so that victims must be chosen.
  task automatic test_eviction();
    for (int i = 0; i < Slots; i++) begin
      send_req(OpPut, 32'h100 + i, $urandom);
    end
    send_req(OpGet, 32'h105, 32'h0);
    send_req(OpGet, 32'h106, 32'h0);
    for (int i = 0; i < 4; i++) begin
      send_req(OpPut, 32'h200 + i, $urandom);
    end
  endtask

  // Hammer one key until its use count pins at the top.
  task automatic test_saturation();
    for (int i = 0; i < 20; i++) begin
      send_req(OpGet, 32'h105, 32'h0);
    end
    send_req(OpPut, 32'h105, 32'hdead_beef);
    send_req(OpPut, 32'h300, 32'h1);
  endtask

  // Capacity zero, above the table size, and lowered below the fill level.
  task automatic test_capacity();
    write_capacity(5'd0);
    send_req(OpPut, 32'h105, 32'h0bad_0bad);
    send_req(OpPut, 32'h400, 32'h1);
    send_req(OpGet, 32'h105, 32'h0);
    send_req(OpGet, 32'h400, 32'h0);
    write_capacity(5'd31);
    send_req(OpPut, 32'h401, 32'h2);
    send_req(OpPut, 32'h402, 32'h3);
    write_capacity(5'd3);
    send_req(OpPut, 32'h403, 32'h4);
    send_req(OpPut, 32'h404, 32'h5);
    send_req(OpGet, 32'h403, 32'h0);
    write_capacity(5'd1);
    send_req(OpPut, 32'h405, 32'h6);
  endtask

  // Random mixes of gets and puts over a small key pool, one capacity per phase.
  task automatic test_random();
    logic [CapWidth-1:0] caps[8];
    caps = '{5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'($urandom_range(2, 15)), 5'd16, 5'd2};
    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      no_gaps = (p == 0);
      for (int i = 0; i < 165; i++) begin
        if (i == 80 && p % 3 == 1) begin
          drain_results();
        end
        send_req($urandom_range(99) < 55 ? OpPut : OpGet, pick_key(), $urandom);
      end
      no_gaps = 1'b0;
    end
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && done) begin
      if (expected_rsp_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("Unexpected result: hit=%0b read_data=%h", rsp.hit, rsp.read_data);
        end
      end else begin
        rsp_t e;
        e = expected_rsp_q.pop_front();
        n_checked++;
        if (e.hit) begin
          n_hits++;
        end
        if (rsp.hit !== e.hit || rsp.read_data !== e.read_data) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("Result %0d: expected hit=%0b data=%h, got hit=%0b data=%h",
                     n_checked, e.hit, e.read_data, rsp.hit, rsp.read_data);
          end
        end
      end
    end
  end

  // The run is stopped if nothing is accepted and no result comes back for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallMax) begin
      $display("Stalled for %0d cycles", StallMax);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < Slots; i++) begin
      shd_valid[i] = 1'b0;
      shd_key[i]   = '0;
      shd_data[i]  = '0;
      shd_count[i] = '0;
      shd_rank[i]  = 0;
    end
    for (int i = 0; i < 24; i++) begin
      key_pool[i] = $urandom;
    end
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'hffff_ffff;
    key_pool[3] = 32'h0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic();
    test_eviction();
    test_saturation();
    test_capacity();
    test_random();
    drain_results();
    $display("Requests sent %0d, results checked %0d, hits %0d, evictions %0d,",
             n_sent, n_checked, n_hits, n_evict);
    $display("capacity writes %0d, mismatches %0d", n_cfg, n_mismatch);
    if (n_mismatch == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
